FILE: hdl/polyline_route_to_pixels_macros.svh
// ----------------------------------------------------------------------------
// Polyline decoder assertion macros
// Concurrent checks used by the top-level module.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_ROUTE_TO_PIXELS_MACROS_SVH
`define POLYLINE_ROUTE_TO_PIXELS_MACROS_SVH

// a holds, so b holds in the same cycle
`define PLRP_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// a holds, so b holds in the next cycle
`define PLRP_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/plrp_pkg.sv
// ----------------------------------------------------------------------------
// Polyline decoder package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package plrp_pkg;

    localparam int PAD        = 5;
    localparam int ACC_W      = 32;
    localparam int CHUNK_W    = 5;
    localparam int CNT_W      = 3;
    localparam int MAX_CHUNKS = 7;
    localparam int SYM_W      = 8;
    localparam int SYM_BIAS   = 63;

    localparam int DIFF_W = ACC_W + 1;
    localparam int MULT_W = 11;
    localparam int PROD_W = DIFF_W + MULT_W;
    localparam int QUOT_W = PROD_W + 1;
    localparam int DEN_W  = ACC_W;
    localparam int PIX_W  = 11;
    localparam int PIX_MAX = 2047;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

    localparam logic [9:0] BOX_LEFT_RST   = 10'd400;
    localparam logic [8:0] BOX_TOP_RST    = 9'd70;
    localparam logic [9:0] BOX_WIDTH_RST  = 10'd280;
    localparam logic [8:0] BOX_HEIGHT_RST = 9'd200;

    localparam logic signed [ACC_W-1:0] BOUND_LOW_RST  = 32'sh7fff_ffff;
    localparam logic signed [ACC_W-1:0] BOUND_HIGH_RST = 32'sh8000_0000;

    typedef struct packed {
        logic [9:0] box_left;
        logic [8:0] box_top;
        logic [9:0] box_width;
        logic [8:0] box_height;
    } box_cfg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic [DEN_W-1:0]         rx;
        logic signed [DIFF_W-1:0] dy;
        logic [DEN_W-1:0]         ry;
        logic                     pen;
    } map_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic busy;
        logic out_held;
    } back_stat_t;

endpackage

FILE: hdl/polyline_route_to_pixels.sv
// Flow: a completed draw point is queued when its last character is
// accepted, then multiplied, divided, offset, clamped and registered.
// Throughput: one character per cycle while the two-entry queue has room;
// the back maps one point at a time, using the 44-step dividers.
// Reset: asynchronous; box registers return to their defaults, sums clear and
// the bounds return to the empty box.
`include "polyline_route_to_pixels_macros.svh"
// ----------------------------------------------------------------------------
// Polyline route to pixels
// Decodes encoded polyline characters and maps each point into a pixel box.
// ----------------------------------------------------------------------------
module polyline_route_to_pixels (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [plrp_pkg::SYM_W-1:0]         symbol,
    input  logic                               start_req,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [plrp_pkg::PIX_W-1:0]         pixel_x,
    output logic [plrp_pkg::PIX_W-1:0]         pixel_y,
    output logic                               pen_down,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    plrp_pkg::box_cfg_t     cfg_reg, cfg_next;
    plrp_pkg::queue_stat_t  q_stat;
    plrp_pkg::back_stat_t   back_stat;
    plrp_pkg::map_job_t     push_job, pop_job;
    logic                   q_push, q_pop, q_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                plrp_pkg::REG_BOX_LEFT:   cfg_next.box_left   = cfg_data[9:0];
                plrp_pkg::REG_BOX_TOP:    cfg_next.box_top    = cfg_data[8:0];
                plrp_pkg::REG_BOX_WIDTH:  cfg_next.box_width  = cfg_data[9:0];
                plrp_pkg::REG_BOX_HEIGHT: cfg_next.box_height = cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_left   <= plrp_pkg::BOX_LEFT_RST;
            cfg_reg.box_top    <= plrp_pkg::BOX_TOP_RST;
            cfg_reg.box_width  <= plrp_pkg::BOX_WIDTH_RST;
            cfg_reg.box_height <= plrp_pkg::BOX_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    plrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .symbol    (symbol),
        .start_req (start_req),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    plrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .pop_valid (q_valid),
        .stat      (q_stat)
    );

    plrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_valid),
        .job       (pop_job),
        .job_pop   (q_pop),
        .stat      (back_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pen_down  (pen_down)
    );

    `PLRP_ASSERT_IMP(a_push_has_room, clk, rst_n, q_push, !q_stat.full)
    `PLRP_ASSERT_IMP(a_pop_has_entry, clk, rst_n, q_pop, !q_stat.empty)
    `PLRP_ASSERT_NXT(a_pop_starts_map, clk, rst_n, q_pop, back_stat.busy)
    `PLRP_ASSERT_NXT(a_held_out_stays, clk, rst_n, back_stat.out_held, out_valid)

endmodule

FILE: hdl/plrp_front.sv
// ----------------------------------------------------------------------------
// Polyline decoder front
// Accepts characters, collects chunks, keeps running sums and bounds, and
// queues completed draw points as mapping requests.
// ----------------------------------------------------------------------------
module plrp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [plrp_pkg::SYM_W-1:0]     symbol,
    input  logic                           start_req,
    input  plrp_pkg::queue_stat_t          q_stat,
    output logic                           q_push,
    output plrp_pkg::map_job_t             q_job
);

    logic [plrp_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [plrp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              lon_sel_reg, lon_sel_next;
    logic [plrp_pkg::ACC_W-1:0]        lat_tot_reg, lat_tot_next;
    logic [plrp_pkg::ACC_W-1:0]        lon_tot_reg, lon_tot_next;
    logic signed [plrp_pkg::ACC_W-1:0] lat_lo_reg, lat_lo_next;
    logic signed [plrp_pkg::ACC_W-1:0] lat_hi_reg, lat_hi_next;
    logic signed [plrp_pkg::ACC_W-1:0] lon_lo_reg, lon_lo_next;
    logic signed [plrp_pkg::ACC_W-1:0] lon_hi_reg, lon_hi_next;
    logic                              prev_reg, prev_next;

    logic                              accept;
    logic [plrp_pkg::SYM_W:0]          diff;
    logic [plrp_pkg::CHUNK_W-1:0]      chunk;
    logic                              cont;
    logic [4:0]                        shamt;
    logic [plrp_pkg::ACC_W-1:0]        acc_e, acc_new, delta;
    logic [plrp_pkg::CNT_W-1:0]        cnt_e;
    logic                              lon_sel_e, prev_e, clr_bounds;
    logic [plrp_pkg::ACC_W-1:0]        lat_tot_e, lon_tot_e, lon_pt;
    logic signed [plrp_pkg::ACC_W-1:0] lat_s, lon_s;
    logic signed [plrp_pkg::ACC_W-1:0] lat_lo_e, lat_hi_e, lon_lo_e, lon_hi_e;
    logic                              point, degen;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        diff  = {1'b0, symbol} - (plrp_pkg::SYM_W + 1)'(plrp_pkg::SYM_BIAS);
        chunk = diff[plrp_pkg::CHUNK_W-1:0];
        cont  = !diff[plrp_pkg::SYM_W] && (diff[plrp_pkg::SYM_W-1:plrp_pkg::CHUNK_W] != '0);

        acc_e      = start_req ? '0 : acc_reg;
        cnt_e      = start_req ? '0 : cnt_reg;
        lon_sel_e  = start_req ? 1'b0 : lon_sel_reg;
        lat_tot_e  = start_req ? '0 : lat_tot_reg;
        lon_tot_e  = start_req ? '0 : lon_tot_reg;
        prev_e     = start_req ? 1'b0 : prev_reg;
        clr_bounds = start_req && !op;
        lat_lo_e   = clr_bounds ? plrp_pkg::BOUND_LOW_RST  : lat_lo_reg;
        lat_hi_e   = clr_bounds ? plrp_pkg::BOUND_HIGH_RST : lat_hi_reg;
        lon_lo_e   = clr_bounds ? plrp_pkg::BOUND_LOW_RST  : lon_lo_reg;
        lon_hi_e   = clr_bounds ? plrp_pkg::BOUND_HIGH_RST : lon_hi_reg;

        shamt = {cnt_e[2:0], 2'b00} + {2'b00, cnt_e[2:0]};
        if (cnt_e < plrp_pkg::CNT_W'(plrp_pkg::MAX_CHUNKS))
        begin
            acc_new  = acc_e | (plrp_pkg::ACC_W'(chunk) << shamt);
            cnt_next = cnt_e + plrp_pkg::CNT_W'(1);
        end
        else
        begin
            acc_new  = acc_e;
            cnt_next = cnt_e;
        end

        delta  = {1'b0, acc_new[plrp_pkg::ACC_W-1:1]} ^ {plrp_pkg::ACC_W{acc_new[0]}};
        lon_pt = lon_tot_e + delta;
        lat_s  = $signed(lat_tot_e);
        lon_s  = $signed(lon_pt);
        point  = !cont && lon_sel_e;
        degen  = (lat_hi_e <= lat_lo_e) || (lon_hi_e <= lon_lo_e);

        acc_next     = acc_new;
        lon_sel_next = lon_sel_e;
        lat_tot_next = lat_tot_e;
        lon_tot_next = lon_tot_e;
        prev_next    = prev_e;
        lat_lo_next  = lat_lo_e;
        lat_hi_next  = lat_hi_e;
        lon_lo_next  = lon_lo_e;
        lon_hi_next  = lon_hi_e;

        if (!cont)
        begin
            acc_next = '0;
            cnt_next = '0;
            if (!lon_sel_e)
            begin
                lat_tot_next = lat_tot_e + delta;
                lon_sel_next = 1'b1;
            end
            else
            begin
                lon_tot_next = lon_pt;
                lon_sel_next = 1'b0;
                if (!op)
                begin
                    if (lat_s < lat_lo_e) lat_lo_next = lat_s;
                    if (lat_s > lat_hi_e) lat_hi_next = lat_s;
                    if (lon_s < lon_lo_e) lon_lo_next = lon_s;
                    if (lon_s > lon_hi_e) lon_hi_next = lon_s;
                end
                else if (!degen)
                begin
                    prev_next = 1'b1;
                end
            end
        end

        q_push   = accept && point && op && !degen;
        q_job.dx = $signed({lon_s[plrp_pkg::ACC_W-1], lon_s})
                 - $signed({lon_lo_e[plrp_pkg::ACC_W-1], lon_lo_e});
        q_job.dy = $signed({lat_s[plrp_pkg::ACC_W-1], lat_s})
                 - $signed({lat_lo_e[plrp_pkg::ACC_W-1], lat_lo_e});
        q_job.rx = lon_hi_e - lon_lo_e;
        q_job.ry = lat_hi_e - lat_lo_e;
        q_job.pen = prev_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            lon_sel_reg <= 1'b0;
            lat_tot_reg <= '0;
            lon_tot_reg <= '0;
            lat_lo_reg  <= plrp_pkg::BOUND_LOW_RST;
            lat_hi_reg  <= plrp_pkg::BOUND_HIGH_RST;
            lon_lo_reg  <= plrp_pkg::BOUND_LOW_RST;
            lon_hi_reg  <= plrp_pkg::BOUND_HIGH_RST;
            prev_reg    <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            lon_sel_reg <= lon_sel_next;
            lat_tot_reg <= lat_tot_next;
            lon_tot_reg <= lon_tot_next;
            lat_lo_reg  <= lat_lo_next;
            lat_hi_reg  <= lat_hi_next;
            lon_lo_reg  <= lon_lo_next;
            lon_hi_reg  <= lon_hi_next;
            prev_reg    <= prev_next;
        end
    end

endmodule

FILE: hdl/plrp_queue.sv
// ----------------------------------------------------------------------------
// Polyline decoder request queue
// Short FIFO of mapping requests between front and back.
// ----------------------------------------------------------------------------
module plrp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  plrp_pkg::map_job_t    push_job,
    input  logic                  pop,
    output plrp_pkg::map_job_t    pop_job,
    output logic                  pop_valid,
    output plrp_pkg::queue_stat_t stat
);

    plrp_pkg::map_job_t                 mem_reg [plrp_pkg::QUEUE_DEPTH];
    logic [plrp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [plrp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [plrp_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;

    function automatic logic [plrp_pkg::QPTR_W-1:0] ptr_inc(
        input logic [plrp_pkg::QPTR_W-1:0] p
    );
        if (p == plrp_pkg::QPTR_W'(plrp_pkg::QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + plrp_pkg::QPTR_W'(1);
    endfunction

    assign stat.full  = (cnt_reg == plrp_pkg::QCNT_W'(plrp_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_valid  = !stat.empty;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + plrp_pkg::QCNT_W'(push) - plrp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hdl/plrp_div.sv
// ----------------------------------------------------------------------------
// Polyline decoder divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module plrp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [plrp_pkg::PROD_W-1:0]  num,
    input  logic [plrp_pkg::DEN_W-1:0]          den,
    output logic                                busy,
    output logic signed [plrp_pkg::QUOT_W-1:0]  quot
);

    localparam int STEP_W = $clog2(plrp_pkg::PROD_W + 1);

    logic                          busy_reg, busy_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [plrp_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [plrp_pkg::PROD_W-1:0]   qr_reg, qr_next;
    logic                          neg_reg, neg_next;
    logic [plrp_pkg::DEN_W:0]      rem_sh, rem_sub;
    logic                          ge;

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed({1'b0, qr_reg}) : $signed({1'b0, qr_reg});

    always_comb
    begin
        rem_sh  = {rem_reg, qr_reg[plrp_pkg::PROD_W-1]};
        rem_sub = rem_sh - {1'b0, den};
        ge      = (rem_sh >= {1'b0, den});

        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        qr_next   = qr_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(plrp_pkg::PROD_W);
            rem_next  = '0;
            neg_next  = num[plrp_pkg::PROD_W-1];
            qr_next   = num[plrp_pkg::PROD_W-1] ? plrp_pkg::PROD_W'(-num)
                                                 : plrp_pkg::PROD_W'(num);
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[plrp_pkg::DEN_W-1:0] : rem_sh[plrp_pkg::DEN_W-1:0];
            qr_next   = {qr_reg[plrp_pkg::PROD_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        neg_reg <= neg_next;
    end

endmodule

FILE: hdl/plrp_back.sv
// ----------------------------------------------------------------------------
// Polyline decoder back
// Maps queued points into the padded box: multiply, divide, offset, clamp,
// and hold the pixel in the output register.
// ----------------------------------------------------------------------------
module plrp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plrp_pkg::box_cfg_t            cfg,
    input  logic                          job_valid,
    input  plrp_pkg::map_job_t            job,
    output logic                          job_pop,
    output plrp_pkg::back_stat_t          stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [plrp_pkg::PIX_W-1:0]    pixel_x,
    output logic [plrp_pkg::PIX_W-1:0]    pixel_y,
    output logic                          pen_down
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_START = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    localparam int SUM_W = plrp_pkg::QUOT_W + 1;

    logic [1:0]                           state_reg, state_next;
    plrp_pkg::map_job_t                   job_reg;
    logic signed [plrp_pkg::PROD_W-1:0]   prod_x_reg, prod_y_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic [plrp_pkg::PIX_W-1:0]           pixel_x_reg, pixel_y_reg;
    logic                                 pen_reg;

    logic signed [plrp_pkg::MULT_W-1:0]   iw, nih;
    logic signed [11:0]                   base_x, base_y;
    logic                                 div_start, busy_x, busy_y, load;
    logic signed [plrp_pkg::QUOT_W-1:0]   quot_x, quot_y;
    logic signed [SUM_W-1:0]              sum_x, sum_y;

    function automatic logic [plrp_pkg::PIX_W-1:0] clamp_pix(
        input logic signed [SUM_W-1:0] v
    );
        if (v < 0)
            clamp_pix = '0;
        else if (v > SUM_W'(plrp_pkg::PIX_MAX))
            clamp_pix = plrp_pkg::PIX_W'(plrp_pkg::PIX_MAX);
        else
            clamp_pix = v[plrp_pkg::PIX_W-1:0];
    endfunction

    assign iw  = $signed({1'b0, cfg.box_width}) - plrp_pkg::MULT_W'(2 * plrp_pkg::PAD);
    assign nih = plrp_pkg::MULT_W'(2 * plrp_pkg::PAD) - $signed({2'b00, cfg.box_height});
    assign base_x = $signed({2'b00, cfg.box_left}) + 12'(plrp_pkg::PAD);
    assign base_y = $signed({3'b000, cfg.box_top}) + $signed({3'b000, cfg.box_height})
                  - 12'(plrp_pkg::PAD);

    assign div_start = (state_reg == S_START);
    assign job_pop   = job_valid && (state_reg == S_IDLE);

    plrp_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_x_reg),
        .den   (job_reg.rx),
        .busy  (busy_x),
        .quot  (quot_x)
    );

    plrp_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_y_reg),
        .den   (job_reg.ry),
        .busy  (busy_y),
        .quot  (quot_y)
    );

    always_comb
    begin
        sum_x = SUM_W'(base_x) + SUM_W'(quot_x);
        sum_y = SUM_W'(base_y) + SUM_W'(quot_y);
        load  = (state_reg == S_DIV) && !busy_x && !busy_y
             && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (job_valid) state_next = S_MUL;
            S_MUL:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (load) state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        if (state_reg == S_MUL)
        begin
            prod_x_reg <= job_reg.dx * iw;
            prod_y_reg <= job_reg.dy * nih;
        end
        if (load)
        begin
            pixel_x_reg <= clamp_pix(sum_x);
            pixel_y_reg <= clamp_pix(sum_y);
            pen_reg     <= job_reg.pen;
        end
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.out_held = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pen_down      = pen_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline decoder testbench
// Streams bounds and draw passes of encoded polyline characters through the
// decoder under several box settings and idling patterns. It predicts every
// pixel point and checks each one in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int ITEM_TARGET   = 850;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 20000;
    localparam int LONG_HOLD     = 600;
    localparam int MAX_REPORTS   = 10;
    localparam int CONT_BIT      = 32;

    typedef enum logic {
        OP_BOUNDS = 1'b0,
        OP_DRAW   = 1'b1
    } pass_op_t;

    typedef struct packed {
        pass_op_t                   op;
        logic [plrp_pkg::SYM_W-1:0] symbol;
        logic                       start;
    } char_req_t;

    typedef struct packed {
        logic [plrp_pkg::PIX_W-1:0] x;
        logic [plrp_pkg::PIX_W-1:0] y;
        logic                       pen;
    } pixel_point_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            op        = 1'b0;
    logic [plrp_pkg::SYM_W-1:0]      symbol    = '0;
    logic                            start_req = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [plrp_pkg::PIX_W-1:0]      pixel_x;
    logic [plrp_pkg::PIX_W-1:0]      pixel_y;
    logic                            pen_down;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [plrp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [plrp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    char_req_t                  chars_to_send [$];
    pixel_point_t               points_due [$];
    logic [plrp_pkg::SYM_W-1:0] route_q [$];
    pixel_point_t               want_point;
    char_req_t                  next_req;
    int                         items_queued   = 0;
    int                         failures       = 0;
    int                         quiet_cycles   = 0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    int                         hold_left      = 0;
    bit                         in_taken       = 1'b0;

    logic [plrp_pkg::ACC_W-1:0]        acc_bits     = '0;
    int unsigned                       acc_shift    = 0;
    logic                              on_longitude = 1'b0;
    logic [plrp_pkg::ACC_W-1:0]        lat_sum      = '0;
    logic [plrp_pkg::ACC_W-1:0]        lon_sum      = '0;
    logic signed [plrp_pkg::ACC_W-1:0] lat_min      = plrp_pkg::BOUND_LOW_RST;
    logic signed [plrp_pkg::ACC_W-1:0] lat_max      = plrp_pkg::BOUND_HIGH_RST;
    logic signed [plrp_pkg::ACC_W-1:0] lon_min      = plrp_pkg::BOUND_LOW_RST;
    logic signed [plrp_pkg::ACC_W-1:0] lon_max      = plrp_pkg::BOUND_HIGH_RST;
    logic                              drew_before  = 1'b0;
    int                                cur_left     = plrp_pkg::BOX_LEFT_RST;
    int                                cur_top      = plrp_pkg::BOX_TOP_RST;
    int                                cur_width    = plrp_pkg::BOX_WIDTH_RST;
    int                                cur_height   = plrp_pkg::BOX_HEIGHT_RST;

    polyline_route_to_pixels u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .symbol    (symbol),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pen_down  (pen_down),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic longint scale_onto(longint v, longint lo, longint hi,
                                          longint a, longint b);
        return a + ((v - lo) * (b - a)) / (hi - lo);
    endfunction

    function automatic logic [plrp_pkg::PIX_W-1:0] to_pixel(longint v);
        if (v < 0)
            return '0;
        if (v > plrp_pkg::PIX_MAX)
            return plrp_pkg::PIX_W'(plrp_pkg::PIX_MAX);
        return v[plrp_pkg::PIX_W-1:0];
    endfunction

    task automatic decode_symbol(input pass_op_t op_i,
                                 input logic [plrp_pkg::SYM_W-1:0] sym,
                                 input logic start);
        int                         diff;
        logic [plrp_pkg::ACC_W-1:0] step;
        longint                     ix;
        longint                     iy;
        longint                     iw;
        longint                     ih;
        pixel_point_t               pt;
        if (start)
        begin
            acc_bits     = '0;
            acc_shift    = 0;
            on_longitude = 1'b0;
            lat_sum      = '0;
            lon_sum      = '0;
            drew_before  = 1'b0;
            if (op_i == OP_BOUNDS)
            begin
                lat_min = plrp_pkg::BOUND_LOW_RST;
                lon_min = plrp_pkg::BOUND_LOW_RST;
                lat_max = plrp_pkg::BOUND_HIGH_RST;
                lon_max = plrp_pkg::BOUND_HIGH_RST;
            end
        end
        diff = int'(sym) - plrp_pkg::SYM_BIAS;
        if (acc_shift < plrp_pkg::CHUNK_W * plrp_pkg::MAX_CHUNKS)
        begin
            step      = {{(plrp_pkg::ACC_W - plrp_pkg::CHUNK_W){1'b0}},
                         diff[plrp_pkg::CHUNK_W-1:0]};
            acc_bits  = acc_bits | (step << acc_shift);
            acc_shift = acc_shift + plrp_pkg::CHUNK_W;
        end
        if (diff >= CONT_BIT)
            return;
        step = acc_bits >> 1;
        if (acc_bits[0])
            step = ~step;
        acc_bits  = '0;
        acc_shift = 0;
        if (!on_longitude)
        begin
            lat_sum      = lat_sum + step;
            on_longitude = 1'b1;
            return;
        end
        lon_sum      = lon_sum + step;
        on_longitude = 1'b0;
        if (op_i == OP_BOUNDS)
        begin
            if ($signed(lat_sum) < lat_min) lat_min = lat_sum;
            if ($signed(lat_sum) > lat_max) lat_max = lat_sum;
            if ($signed(lon_sum) < lon_min) lon_min = lon_sum;
            if ($signed(lon_sum) > lon_max) lon_max = lon_sum;
            return;
        end
        if (lat_max <= lat_min || lon_max <= lon_min)
            return;
        ix = cur_left + plrp_pkg::PAD;
        iy = cur_top + plrp_pkg::PAD;
        iw = cur_width - 2 * plrp_pkg::PAD;
        ih = cur_height - 2 * plrp_pkg::PAD;
        pt.x   = to_pixel(scale_onto($signed(lon_sum), lon_min, lon_max, ix, ix + iw));
        pt.y   = to_pixel(scale_onto($signed(lat_sum), lat_min, lat_max, iy + ih, iy));
        pt.pen = drew_before;
        drew_before = 1'b1;
        points_due.push_back(pt);
    endtask

    task automatic queue_char(input pass_op_t op_i, input logic [plrp_pkg::SYM_W-1:0] sym,
                              input logic start);
        char_req_t req;
        req.op     = op_i;
        req.symbol = sym;
        req.start  = start;
        chars_to_send.push_back(req);
        items_queued++;
    endtask

    task automatic append_value(input logic [plrp_pkg::ACC_W-1:0] delta);
        logic [plrp_pkg::ACC_W-1:0] zig;
        logic [plrp_pkg::SYM_W-1:0] c;
        zig = (delta << 1) ^ {plrp_pkg::ACC_W{delta[plrp_pkg::ACC_W-1]}};
        while (zig >= CONT_BIT)
        begin
            c = plrp_pkg::SYM_W'(plrp_pkg::SYM_BIAS + CONT_BIT
                                 + zig[plrp_pkg::CHUNK_W-1:0]);
            route_q.push_back(c);
            zig = zig >> plrp_pkg::CHUNK_W;
        end
        c = plrp_pkg::SYM_W'(plrp_pkg::SYM_BIAS + zig[plrp_pkg::CHUNK_W-1:0]);
        route_q.push_back(c);
    endtask

    function automatic logic [plrp_pkg::ACC_W-1:0] random_delta(int reach);
        if (reach == 0)
            return $urandom;
        return $urandom_range(2 * reach) - reach;
    endfunction

    task automatic make_route(input int points, input int reach, input bit flat,
                              input bit ragged);
        int                         r;
        logic [plrp_pkg::SYM_W-1:0] c;
        route_q.delete();
        for (int k = 0; k < 2 * points; k++)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                repeat ($urandom_range(plrp_pkg::MAX_CHUNKS + 1, plrp_pkg::MAX_CHUNKS + 3))
                begin
                    c = plrp_pkg::SYM_W'($urandom_range(255,
                                                        plrp_pkg::SYM_BIAS + CONT_BIT));
                    route_q.push_back(c);
                end
                c = plrp_pkg::SYM_W'($urandom_range(plrp_pkg::SYM_BIAS + CONT_BIT - 1, 0));
                route_q.push_back(c);
            end
            else if (r < 7)
            begin
                c = plrp_pkg::SYM_W'($urandom_range(255));
                route_q.push_back(c);
            end
            else if (flat && k % 2 == 0)
                append_value('0);
            else
                append_value(random_delta(reach));
        end
        if (ragged)
            append_value(random_delta(reach));
    endtask

    task automatic send_pass(input pass_op_t op_i, input bit restarts);
        foreach (route_q[i])
            queue_char(op_i, route_q[i], i == 0 || (restarts && $urandom_range(63) == 0));
    endtask

    task automatic random_route();
        int pick;
        int reach;
        int npts;
        pick = $urandom_range(99);
        case ($urandom_range(9)) inside
            [0:5]:   reach = 200;
            [6:8]:   reach = 1 << 20;
            default: reach = 0;
        endcase
        if (pick < 6)
        begin
            repeat ($urandom_range(3, 12))
                queue_char(pass_op_t'($urandom_range(1)),
                           plrp_pkg::SYM_W'($urandom_range(255)),
                           $urandom_range(3) == 0);
            return;
        end
        npts = $urandom_range(1, 7);
        make_route(npts, reach, $urandom_range(9) == 0, $urandom_range(7) == 0);
        if (pick >= 14)
            send_pass(OP_BOUNDS, 1'b1);
        // draw a different route against the old extent
        if (pick >= 14 && pick < 26)
            make_route(npts, 4 * reach, 1'b0, 1'b0);
        send_pass(OP_DRAW, 1'b1);
    endtask

    task automatic queue_routes(input int count);
        int goal;
        goal = items_queued + count;
        while (items_queued < goal)
            random_route();
    endtask

    task automatic write_register(input logic [plrp_pkg::CFG_IDX_W-1:0] idx,
                                  input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[plrp_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            plrp_pkg::REG_BOX_LEFT:   cur_left   = value[9:0];
            plrp_pkg::REG_BOX_TOP:    cur_top    = value[8:0];
            plrp_pkg::REG_BOX_WIDTH:  cur_width  = value[9:0];
            plrp_pkg::REG_BOX_HEIGHT: cur_height = value[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int left, input int top, input int width,
                             input int height);
        write_register(plrp_pkg::REG_BOX_LEFT, left);
        write_register(plrp_pkg::REG_BOX_TOP, top);
        write_register(plrp_pkg::REG_BOX_WIDTH, width);
        write_register(plrp_pkg::REG_BOX_HEIGHT, height);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (chars_to_send.size() != 0 || in_valid || points_due.size() != 0);
    endtask

    task automatic settle();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // hold the request until it is taken
            if (!in_valid || in_taken)
            begin
                if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req  = chars_to_send.pop_front();
                    in_valid  <= 1'b1;
                    op        <= next_req.op;
                    symbol    <= next_req.symbol;
                    start_req <= next_req.start;
                end
                else
                    in_valid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_symbol(pass_op_t'(op), symbol, start_req);
                in_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("unexpected point: x=%0d y=%0d pen=%0b",
                                 pixel_x, pixel_y, pen_down);
                end
                else
                begin
                    want_point = points_due.pop_front();
                    if (pixel_x !== want_point.x || pixel_y !== want_point.y ||
                        pen_down !== want_point.pen)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("point mismatch: expected x=%0d y=%0d pen=%0b, %s",
                                     want_point.x, want_point.y, want_point.pen,
                                     $sformatf("got x=%0d y=%0d pen=%0b",
                                               pixel_x, pixel_y, pen_down));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // draw with an empty extent: no point
        queue_char(OP_DRAW, plrp_pkg::SYM_W'(plrp_pkg::SYM_BIAS), 1'b1);
        queue_char(OP_DRAW, plrp_pkg::SYM_W'(plrp_pkg::SYM_BIAS), 1'b0);
        route_q.delete();
        append_value('0);
        append_value('0);
        append_value(-500);
        append_value(700);
        send_pass(OP_BOUNDS, 1'b0);
        send_pass(OP_DRAW, 1'b0);
        // low symbol ends a value; high symbols continue past the seventh chunk
        queue_char(OP_DRAW, 8'd0, 1'b0);
        queue_char(OP_DRAW, 8'd255, 1'b0);
        queue_char(OP_DRAW, 8'd126, 1'b0);
        queue_char(OP_DRAW, 8'd127, 1'b0);
        queue_char(OP_DRAW, 8'd95, 1'b0);
        queue_char(OP_DRAW, 8'd200, 1'b0);
        repeat (3) queue_char(OP_DRAW, 8'd255, 1'b0);
        queue_char(OP_DRAW, 8'd94, 1'b0);
        // leave a point unfinished
        queue_char(OP_DRAW, 8'd70, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    configure(0, 0, 11, 11);
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                    configure(799, 479, 800, 480);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                    configure($urandom_range(799), $urandom_range(479),
                              $urandom_range(800, 11), $urandom_range(480, 11));
                end
                3:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                    configure($urandom_range(799), $urandom_range(479),
                              $urandom_range(800, 11), $urandom_range(480, 11));
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    configure(799, 0, 11, 480);
                end
            endcase
            if (p == PHASES - 1)
            begin
                @(posedge clk);
                hold_left = LONG_HOLD;
                queue_routes(ITEM_TARGET / PHASES / 2);
                wait_until_drained();
                queue_routes(ITEM_TARGET / PHASES / 2);
            end
            else
                queue_routes(ITEM_TARGET / PHASES);
            settle();
        end

        if (points_due.size() != 0)
            failures++;
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
